// ===== hdl/tpbe_pkg.sv =====
// ============================================================================
// tpbe_pkg
// Shared types, widths, codes and header table for the thermal BMP encoder.
// ============================================================================
`default_nettype none

package tpbe_pkg;

    // Image geometry
    localparam int IMAGE_WIDTH  = 96;
    localparam int IMAGE_HEIGHT = 72;

    // Field widths
    localparam int KIND_W  = 2;
    localparam int PIDX_W  = 8;
    localparam int COLOR_W = 16;
    localparam int TEMP_W  = 11;
    localparam int BYTE_W  = 8;
    localparam int CIDX_W  = 1;

    // Internal arithmetic widths
    localparam int DIFF_W = 13;   // temperature minus low limit, and span
    localparam int NUM_W  = 21;   // signed numerator, diff * 255
    localparam int DNUM_W = 19;   // non-negative numerator fed to the divider
    localparam int DEN_W  = 12;   // positive span fed to the divider
    localparam int COL_W  = (IMAGE_WIDTH > 1) ? $clog2(IMAGE_WIDTH) : 1;
    localparam int HCNT_W = 6;
    localparam int PAD_W  = 2;

    // Item kinds
    localparam logic [KIND_W-1:0] KIND_PALETTE = 2'd0;
    localparam logic [KIND_W-1:0] KIND_HEADER  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_PIXEL   = 2'd2;

    // Configuration register indexes
    localparam logic [CIDX_W-1:0] CFG_MIN_TEMP = 1'b0;
    localparam logic [CIDX_W-1:0] CFG_MAX_TEMP = 1'b1;

    // Configuration reset values
    localparam logic signed [TEMP_W-1:0] MIN_TEMP_RST = 11'sd20;
    localparam logic signed [TEMP_W-1:0] MAX_TEMP_RST = 11'sd35;

    // Temperature widening margin
    localparam logic signed [DIFF_W-1:0] MARGIN     = 13'sd5;
    localparam logic signed [DIFF_W-1:0] MARGIN_TWO = 13'sd10;

    // RGB565 to RGB888 expansion
    localparam int C5_MUL = 527;
    localparam int C5_ADD = 23;
    localparam int C6_MUL = 259;
    localparam int C6_ADD = 33;

    // BMP layout
    localparam int HDR_BYTES  = 54;
    localparam int INFO_BYTES = 40;
    localparam int BPP        = 24;
    localparam int ROW_BYTES  = IMAGE_WIDTH * 3;
    localparam int ROW_PAD    = (4 - (ROW_BYTES % 4)) % 4;
    localparam int IMG_BYTES  = (ROW_BYTES + ROW_PAD) * IMAGE_HEIGHT;
    localparam int FILE_BYTES = IMG_BYTES + HDR_BYTES;

    localparam logic [31:0] FILE_BYTES_32 = 32'(FILE_BYTES);
    localparam logic [31:0] IMG_BYTES_32  = 32'(IMG_BYTES);
    localparam logic [31:0] HDR_BYTES_32  = 32'(HDR_BYTES);
    localparam logic [31:0] INFO_BYTES_32 = 32'(INFO_BYTES);
    localparam logic [31:0] WIDTH_32      = 32'(IMAGE_WIDTH);
    localparam logic [31:0] HEIGHT_32     = 32'(IMAGE_HEIGHT);
    localparam logic [31:0] BPP_32        = 32'(BPP);

    localparam logic [HCNT_W-1:0] HDR_LAST = HCNT_W'(HDR_BYTES - 1);
    localparam logic [COL_W-1:0]  COL_LAST = COL_W'(IMAGE_WIDTH - 1);
    localparam logic [PAD_W-1:0]  PAD_INIT = PAD_W'((ROW_PAD > 0) ? ROW_PAD - 1 : 0);

    // Divider request and response
    typedef struct packed {
        logic              valid;
        logic [DNUM_W-1:0] num;
        logic [DEN_W-1:0]  den;
    } t_div_req;

    typedef struct packed {
        logic        valid;
        logic [7:0]  quo;
    } t_div_rsp;

    // BMP file and info header, one byte per position
    function automatic logic [BYTE_W-1:0] hdr_byte(input logic [HCNT_W-1:0] pos);
        logic [BYTE_W-1:0] b;
        b = '0;
        case (pos)
            6'd0:  b = 8'h42;
            6'd1:  b = 8'h4D;
            6'd2:  b = FILE_BYTES_32[7:0];
            6'd3:  b = FILE_BYTES_32[15:8];
            6'd4:  b = FILE_BYTES_32[23:16];
            6'd5:  b = FILE_BYTES_32[31:24];
            6'd10: b = HDR_BYTES_32[7:0];
            6'd11: b = HDR_BYTES_32[15:8];
            6'd14: b = INFO_BYTES_32[7:0];
            6'd15: b = INFO_BYTES_32[15:8];
            6'd18: b = WIDTH_32[7:0];
            6'd19: b = WIDTH_32[15:8];
            6'd20: b = WIDTH_32[23:16];
            6'd21: b = WIDTH_32[31:24];
            6'd22: b = HEIGHT_32[7:0];
            6'd23: b = HEIGHT_32[15:8];
            6'd24: b = HEIGHT_32[23:16];
            6'd25: b = HEIGHT_32[31:24];
            6'd26: b = 8'h01;
            6'd28: b = BPP_32[7:0];
            6'd34: b = IMG_BYTES_32[7:0];
            6'd35: b = IMG_BYTES_32[15:8];
            6'd36: b = IMG_BYTES_32[23:16];
            6'd37: b = IMG_BYTES_32[31:24];
            default: b = '0;
        endcase
        return b;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/tpbe_ifs.sv =====
// ============================================================================
// tpbe channel interfaces
// Valid/ready channels for input items, output bytes and register writes.
// ============================================================================
`default_nettype none

interface tpbe_in_if import tpbe_pkg::*; ();
    logic                        valid;
    logic                        ready;
    logic [KIND_W-1:0]           kind;
    logic [PIDX_W-1:0]           palette_index;
    logic [COLOR_W-1:0]          palette_color;
    logic signed [TEMP_W-1:0]    temperature;

    modport source (output valid, kind, palette_index, palette_color, temperature,
                    input ready);
    modport sink   (input valid, kind, palette_index, palette_color, temperature,
                    output ready);
endinterface

interface tpbe_out_if import tpbe_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] out_byte;
    logic              last_byte;

    modport source (output valid, out_byte, last_byte, input ready);
    modport sink   (input valid, out_byte, last_byte, output ready);
endinterface

interface tpbe_cfg_if import tpbe_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [CIDX_W-1:0]        reg_index;
    logic [TEMP_W-1:0]        data;

    modport source (output valid, reg_index, data, input ready);
    modport sink   (input valid, reg_index, data, output ready);
endinterface

`default_nettype wire

// ===== hdl/thermal_palette_bmp_encoder_top.sv =====
// Pixel word: after acceptance it passes the mapping state, the divider, the palette read
// and the blue, green and red byte states, then any row pad bytes at the end of a row; the
// divider answers without iterating on saturation and is skipped for a negative value or empty span.
// Header word: 54 output bytes. Palette write: no output. Output stalls hold the sequence.
// One item in flight; the final byte may wait in the output register while the next
// word is accepted. Synchronous active-low reset restores the limits, column, state and output valid.
// ============================================================================
// thermal_palette_bmp_encoder_top
// Maps temperatures through a 256-entry RGB565 palette RAM to a 24-bit BMP stream.
// ============================================================================
`default_nettype none

module thermal_palette_bmp_encoder_top import tpbe_pkg::*; (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    tpbe_cfg_if.sink    i_cfg,
    tpbe_in_if.sink     i_in,
    tpbe_out_if.source  o_out
);

    // Sequencer states
    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_PREP = 4'd1;
    localparam logic [3:0] ST_DIV  = 4'd2;
    localparam logic [3:0] ST_READ = 4'd3;
    localparam logic [3:0] ST_EB   = 4'd4;
    localparam logic [3:0] ST_EG   = 4'd5;
    localparam logic [3:0] ST_ER   = 4'd6;
    localparam logic [3:0] ST_PAD  = 4'd7;
    localparam logic [3:0] ST_HDR  = 4'd8;

    logic [3:0]               r_state, n_state;
    logic signed [TEMP_W-1:0] r_min, r_max;
    logic signed [TEMP_W-1:0] r_temp, n_temp;
    logic [7:0]               r_idx, n_idx;
    logic [COL_W-1:0]         r_col, n_col;
    logic [HCNT_W-1:0]        r_hcnt, n_hcnt;
    logic [PAD_W-1:0]         r_pad, n_pad;
    logic                     r_ovalid, n_ovalid;
    logic [BYTE_W-1:0]        r_obyte, n_obyte;
    logic                     r_olast, n_olast;
    logic [COLOR_W-1:0]       r_rd_data;

    logic [COLOR_W-1:0]       mem_palette [256];

    logic                     w_in_acc;
    logic                     w_out_free;
    logic signed [DIFF_W-1:0] w_diff;
    logic signed [DIFF_W-1:0] w_span;
    logic signed [NUM_W-1:0]  w_num;
    logic [14:0]              w_r_ext, w_g_ext, w_b_ext;
    t_div_req                 w_req;
    t_div_rsp                 w_rsp;

    // Handshakes
    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = (r_state == ST_IDLE);
    assign w_in_acc    = i_in.valid && (r_state == ST_IDLE);
    assign w_out_free  = !r_ovalid || o_out.ready;

    // Limit registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min <= MIN_TEMP_RST;
            r_max <= MAX_TEMP_RST;
        end else if (i_cfg.valid) begin
            case (i_cfg.reg_index)
                CFG_MIN_TEMP: r_min <= i_cfg.data;
                CFG_MAX_TEMP: r_max <= i_cfg.data;
                default: ;
            endcase
        end
    end

    // Palette RAM: write on palette words, registered read before emission
    always_ff @(posedge i_clk) begin
        if (w_in_acc && (i_in.kind == KIND_PALETTE)) begin
            mem_palette[i_in.palette_index] <= i_in.palette_color;
        end
        if (r_state == ST_READ) begin
            r_rd_data <= mem_palette[r_idx];
        end
    end

    // Linear map numerator (t - lo) * 255 and span hi - lo
    assign w_diff = DIFF_W'(r_temp) - DIFF_W'(r_min) + MARGIN;
    assign w_span = DIFF_W'(r_max) - DIFF_W'(r_min) + MARGIN_TWO;
    assign w_num  = (NUM_W'(w_diff) <<< 8) - NUM_W'(w_diff);

    assign w_req.valid = (r_state == ST_PREP) && (w_span > 0) && !w_num[NUM_W-1];
    assign w_req.num   = w_num[DNUM_W-1:0];
    assign w_req.den   = w_span[DEN_W-1:0];

    tpbe_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_rsp   (w_rsp)
    );

    // Expand RGB565 entry to 8-bit channels
    assign w_r_ext = 15'(r_rd_data[15:11]) * 15'(C5_MUL) + 15'(C5_ADD);
    assign w_g_ext = 15'(r_rd_data[10:5])  * 15'(C6_MUL) + 15'(C6_ADD);
    assign w_b_ext = 15'(r_rd_data[4:0])   * 15'(C5_MUL) + 15'(C5_ADD);

    // Sequencer and output register
    always_comb begin
        n_state  = r_state;
        n_temp   = r_temp;
        n_idx    = r_idx;
        n_col    = r_col;
        n_hcnt   = r_hcnt;
        n_pad    = r_pad;
        n_obyte  = r_obyte;
        n_olast  = r_olast;
        n_ovalid = r_ovalid && !o_out.ready;
        case (r_state)
            ST_IDLE: begin
                if (w_in_acc) begin
                    n_temp = i_in.temperature;
                    case (i_in.kind)
                        KIND_HEADER: begin
                            n_state = ST_HDR;
                            n_hcnt  = '0;
                            n_col   = '0;
                        end
                        KIND_PIXEL: n_state = ST_PREP;
                        default: ;
                    endcase
                end
            end
            ST_PREP: begin
                if (w_req.valid) begin
                    n_state = ST_DIV;
                end else begin
                    n_idx   = '0;
                    n_state = ST_READ;
                end
            end
            ST_DIV: begin
                if (w_rsp.valid) begin
                    n_idx   = w_rsp.quo;
                    n_state = ST_READ;
                end
            end
            ST_READ: n_state = ST_EB;
            ST_EB: begin
                if (w_out_free) begin
                    n_ovalid = 1'b1;
                    n_obyte  = w_b_ext[13:6];
                    n_olast  = 1'b0;
                    n_state  = ST_EG;
                end
            end
            ST_EG: begin
                if (w_out_free) begin
                    n_ovalid = 1'b1;
                    n_obyte  = w_g_ext[13:6];
                    n_olast  = 1'b0;
                    n_state  = ST_ER;
                end
            end
            ST_ER: begin
                if (w_out_free) begin
                    n_ovalid = 1'b1;
                    n_obyte  = w_r_ext[13:6];
                    n_olast  = 1'b1;
                    n_state  = ST_IDLE;
                    if (r_col == COL_LAST) begin
                        n_col = '0;
                        if (ROW_PAD != 0) begin
                            n_olast = 1'b0;
                            n_pad   = PAD_INIT;
                            n_state = ST_PAD;
                        end
                    end else begin
                        n_col = r_col + COL_W'(1);
                    end
                end
            end
            ST_PAD: begin
                if (w_out_free) begin
                    n_ovalid = 1'b1;
                    n_obyte  = '0;
                    n_olast  = (r_pad == '0);
                    n_pad    = r_pad - PAD_W'(1);
                    if (r_pad == '0) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            ST_HDR: begin
                if (w_out_free) begin
                    n_ovalid = 1'b1;
                    n_obyte  = hdr_byte(r_hcnt);
                    n_olast  = (r_hcnt == HDR_LAST);
                    n_hcnt   = r_hcnt + HCNT_W'(1);
                    if (r_hcnt == HDR_LAST) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_col    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_col    <= n_col;
            r_ovalid <= n_ovalid;
        end
        r_temp  <= n_temp;
        r_idx   <= n_idx;
        r_hcnt  <= n_hcnt;
        r_pad   <= n_pad;
        r_obyte <= n_obyte;
        r_olast <= n_olast;
    end

    assign o_out.valid     = r_ovalid;
    assign o_out.out_byte  = r_obyte;
    assign o_out.last_byte = r_olast;

endmodule

`default_nettype wire

// ===== hdl/tpbe_div.sv =====
// ============================================================================
// tpbe_div
// Restoring divider for the palette index: one quotient bit per cycle,
// quotient saturated to 255 by a single up-front compare.
// ============================================================================
`default_nettype none

module tpbe_div import tpbe_pkg::*; (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_div_req i_req,
    output t_div_rsp      o_rsp
);

    logic              r_busy, n_busy;
    logic              r_done, n_done;
    logic [2:0]        r_step, n_step;
    logic [DNUM_W-1:0] r_rem,  n_rem;
    logic [DNUM_W-1:0] r_dsh,  n_dsh;
    logic [7:0]        r_quo,  n_quo;

    logic [DNUM_W:0]   w_trial;
    logic              w_sat;

    // Saturate when the quotient would reach 256 or more
    assign w_sat   = {1'b0, i_req.num} >= {i_req.den, 8'b0};
    assign w_trial = {1'b0, r_rem} - {1'b0, r_dsh};

    // Load, then subtract one shifted divisor per cycle
    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_step = r_step;
        n_rem  = r_rem;
        n_dsh  = r_dsh;
        n_quo  = r_quo;
        if (i_req.valid) begin
            if (w_sat) begin
                n_quo  = 8'hFF;
                n_done = 1'b1;
            end else begin
                n_busy = 1'b1;
                n_step = 3'd7;
                n_rem  = i_req.num;
                n_dsh  = {i_req.den, 7'b0};
                n_quo  = '0;
            end
        end else if (r_busy) begin
            if (!w_trial[DNUM_W]) begin
                n_rem = w_trial[DNUM_W-1:0];
                n_quo = {r_quo[6:0], 1'b1};
            end else begin
                n_quo = {r_quo[6:0], 1'b0};
            end
            n_dsh  = r_dsh >> 1;
            n_step = r_step - 3'd1;
            if (r_step == 3'd0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_step <= n_step;
        r_rem  <= n_rem;
        r_dsh  <= n_dsh;
        r_quo  <= n_quo;
    end

    assign o_rsp.valid = r_done;
    assign o_rsp.quo   = r_quo;

endmodule

`default_nettype wire
